// File: design/rsso_pkg.sv
// rsso_pkg: shared types and constants for the row sorted set operation block
// no dependencies
`default_nettype none
package rsso_pkg;
	localparam int ROW_MAX = 16;
	localparam int IDX_W = $clog2(ROW_MAX);
	localparam int CNT_W = $clog2(ROW_MAX + 1);
	localparam int FIFO_DEPTH = 2;
	localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [1:0] OP_A_MINUS_B = 2'd0;
	localparam logic [1:0] OP_B_MINUS_A = 2'd1;
	localparam logic [1:0] OP_INTERSECT = 2'd2;
	localparam logic [1:0] OP_UNION = 2'd3;
	localparam logic [1:0] CFG_SET_OP = 2'd0;
	localparam logic [1:0] CFG_FIRST_LEN = 2'd1;
	localparam logic [1:0] CFG_SECOND_LEN = 2'd2;
	localparam logic [1:0] CFG_GROUP_COUNT = 2'd3;

	typedef struct packed {
		logic [63:0] value;
		logic        second;
		logic        row_end;
	} beat_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] group_index;
		logic [4:0]  position;
		logic [63:0] element;
		logic        last_in_group;
		logic [5:0]  max_set_size;
		logic [39:0] total_count;
	} result_t;

	function automatic logic [CNT_W-1:0] clamp_len(input logic [4:0] len);
		if (len == 5'd0) return CNT_W'(1);
		if (32'(len) > ROW_MAX) return CNT_W'(ROW_MAX);
		return CNT_W'(len);
	endfunction
endpackage
`default_nettype wire

// File: design/rsso_front.sv
// rsso_front: counts row beats, tags each value with its operand and row end
// depends on rsso_pkg
`default_nettype none
module rsso_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic [63:0]    value,
	input  wire logic [4:0]     first_len,
	input  wire logic [4:0]     second_len,
	output rsso_pkg::beat_t     beat,
	output logic                beat_valid,
	input  wire logic           beat_ready
);
	import rsso_pkg::*;
	logic             second_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_next;
	logic             hit;

	assign full = !beat_ready;
	assign beat_valid = push && beat_ready;
	assign fill_next = fill_q + CNT_W'(1);
	assign hit = fill_next >= clamp_len(second_q ? second_len : first_len);
	assign beat.value = value;
	assign beat.second = second_q;
	assign beat.row_end = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			fill_q <= '0;
		end else if (beat_valid) begin
			if (hit) begin
				fill_q <= '0;
				second_q <= !second_q;
			end else begin
				fill_q <= fill_next;
			end
		end
	end
endmodule
`default_nettype wire

// File: design/rsso_fifo.sv
// rsso_fifo: short beat queue between front and back
// depends on rsso_pkg
`default_nettype none
module rsso_fifo (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  rsso_pkg::beat_t wr_data,
	input  wire logic       wr_en,
	output logic            wr_ready,
	output rsso_pkg::beat_t rd_data,
	output logic            rd_valid,
	input  wire logic       rd_en
);
	import rsso_pkg::*;
	localparam int PW = $clog2(FIFO_DEPTH);
	beat_t         mem_q [FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign wr_ready = 32'(cnt_q) < FIFO_DEPTH;
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= PW'(32'(wp_q) + 1 == FIFO_DEPTH ? 0 : 32'(wp_q) + 1);
			if (rd_en) rp_q <= PW'(32'(rp_q) + 1 == FIFO_DEPTH ? 0 : 32'(rp_q) + 1);
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end
endmodule
`default_nettype wire

// File: design/rsso_back.sv
// rsso_back: sorted insertion into two row stores, merge and result emission
// depends on rsso_pkg
`default_nettype none
module rsso_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  rsso_pkg::beat_t  beat,
	input  wire logic        beat_valid,
	output logic             beat_take,
	input  wire logic [1:0]  set_op,
	input  wire logic [31:0] group_count,
	output rsso_pkg::result_t res,
	output logic             res_valid,
	input  wire logic        res_ready
);
	import rsso_pkg::*;
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_SUM = 2'd2;

	logic [1:0]       state_q;
	logic [63:0]      a_q [ROW_MAX];
	logic [63:0]      b_q [ROW_MAX];
	logic [CNT_W-1:0] na_q, nb_q, i_q, j_q;
	logic [5:0]       nr_q, largest_q;
	logic [39:0]      total_q;
	logic [31:0]      grp_q;
	result_t          res_q;
	logic             res_v_q;

	// insertion: shift greater entries up, drop duplicates
	logic [63:0]      ins_src [ROW_MAX];
	logic [CNT_W-1:0] ins_n;
	logic             dup;
	logic [ROW_MAX-1:0] gt;
	always_comb begin
		for (int k = 0; k < ROW_MAX; k++) ins_src[k] = beat.second ? b_q[k] : a_q[k];
		ins_n = beat.second ? nb_q : na_q;
		dup = 1'b0;
		for (int k = 0; k < ROW_MAX; k++) begin
			gt[k] = (CNT_W'(k) < ins_n) && ($signed(ins_src[k]) > $signed(beat.value));
			if ((CNT_W'(k) < ins_n) && ins_src[k] == beat.value) dup = 1'b1;
		end
	end

	// merge step
	logic        ha, hb, ta, tb, take;
	logic [63:0] ea, eb, x;
	logic [5:0]  nr_next;
	always_comb begin
		ha = i_q < na_q;
		hb = j_q < nb_q;
		ea = a_q[i_q[IDX_W-1:0]];
		eb = b_q[j_q[IDX_W-1:0]];
		ta = 1'b0;
		tb = 1'b0;
		take = 1'b0;
		if (ha && (!hb || $signed(ea) < $signed(eb))) begin
			ta = 1'b1;
			take = set_op == OP_A_MINUS_B || set_op == OP_UNION;
		end else if (!ha || $signed(eb) < $signed(ea)) begin
			tb = 1'b1;
			take = set_op == OP_B_MINUS_A || set_op == OP_UNION;
		end else begin
			ta = 1'b1;
			tb = 1'b1;
			take = set_op == OP_INTERSECT || set_op == OP_UNION;
		end
		x = ta ? ea : eb;
		nr_next = nr_q + 6'(take);
	end

	// hold one pending element so the last flag is known when it leaves
	logic        pend_q;
	logic [63:0] pend_x_q;
	logic [4:0]  pend_pos_q;

	logic        out_free, done_merge, job_end, emit;
	logic [39:0] tot_sum;
	logic [40:0] tot_wide;
	logic [5:0]  largest_new;
	assign out_free = !res_v_q || res_ready;
	assign done_merge = !ha && !hb;
	assign largest_new = nr_q > largest_q ? nr_q : largest_q;
	assign tot_wide = {1'b0, total_q} + 41'(nr_q);
	assign tot_sum = tot_wide > 41'(TOTAL_MAX) ? TOTAL_MAX : tot_wide[39:0];
	assign job_end = (grp_q + 32'd1 >= (group_count == 32'd0 ? 32'd1 : group_count))
		|| grp_q == 32'hFFFF_FFFF;
	assign emit = out_free && ((state_q == ST_MERGE && pend_q && (done_merge || take))
		|| state_q == ST_SUM);
	assign beat_take = state_q == ST_LOAD && beat_valid;
	assign res = res_q;
	assign res_valid = res_v_q;

	always_ff @(posedge clk) begin
		if (beat_take && !dup) begin
			for (int k = 0; k < ROW_MAX; k++) begin
				if (gt[k]) begin
					if (k + 1 < ROW_MAX) begin
						if (beat.second) b_q[(k+1)%ROW_MAX] <= b_q[k];
						else a_q[(k+1)%ROW_MAX] <= a_q[k];
					end
				end
				if ((CNT_W'(k) == ins_n && !(|gt)) ||
				    (gt[k] && (k == 0 || !gt[(k+ROW_MAX-1)%ROW_MAX]))) begin
					if (beat.second) b_q[k] <= beat.value;
					else a_q[k] <= beat.value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			na_q <= '0;
			nb_q <= '0;
			i_q <= '0;
			j_q <= '0;
			nr_q <= '0;
			largest_q <= '0;
			total_q <= '0;
			grp_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
			pend_q <= 1'b0;
			pend_x_q <= '0;
			pend_pos_q <= '0;
		end else begin
			if (emit) res_v_q <= 1'b1;
			else if (res_ready) res_v_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (beat_take) begin
						if (!dup) begin
							if (beat.second) nb_q <= nb_q + CNT_W'(1);
							else na_q <= na_q + CNT_W'(1);
						end
						if (beat.row_end && beat.second) begin
							state_q <= ST_MERGE;
							i_q <= '0;
							j_q <= '0;
							nr_q <= '0;
						end
					end
				end
				ST_MERGE: begin
					if (out_free) begin
						if (!done_merge) begin
							i_q <= i_q + CNT_W'(ta);
							j_q <= j_q + CNT_W'(tb);
							if (take) begin
								nr_q <= nr_next;
								pend_q <= 1'b1;
								pend_x_q <= x;
								pend_pos_q <= nr_q[4:0];
								if (pend_q) begin
									res_q <= '{1'b0, grp_q, pend_pos_q, pend_x_q, 1'b0, 6'd0, 40'd0};
								end
							end
						end else begin
							if (pend_q) begin
								res_q <= '{1'b0, grp_q, pend_pos_q, pend_x_q, 1'b1, 6'd0, 40'd0};
								pend_q <= 1'b0;
							end
							largest_q <= largest_new;
							total_q <= tot_sum;
							na_q <= '0;
							nb_q <= '0;
							if (job_end) state_q <= ST_SUM;
							else begin
								grp_q <= grp_q + 32'd1;
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						res_q <= '{1'b1, 32'd0, 5'd0, 64'd0, 1'b0, largest_q, total_q};
						grp_q <= '0;
						largest_q <= '0;
						total_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/row_sorted_set_operation_top.sv
// row_sorted_set_operation_top: config registers, front, beat queue, back
// depends on rsso_pkg, rsso_front, rsso_fifo, rsso_back
// a value is accepted into the beat queue, then inserted into its row store
// a row pair merges one distinct value of both rows per step, then closes the group;
// each step is held while a result waits to be popped; the summary comes last
// reset clears all control state asynchronously; the row stores are not cleared
`default_nettype none
module row_sorted_set_operation_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] value,
	output logic             empty,
	input  wire logic        pop,
	output logic             kind,
	output logic [31:0]      group_index,
	output logic [4:0]       position,
	output logic [63:0]      element,
	output logic             last_in_group,
	output logic [5:0]       max_set_size,
	output logic [39:0]      total_count,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import rsso_pkg::*;
	logic [1:0]  set_op_q;
	logic [4:0]  first_len_q, second_len_q;
	logic [31:0] group_count_q;
	beat_t       fb, bb;
	logic        fv, fr, bv, bt, rv;
	result_t     r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_op_q <= OP_A_MINUS_B;
			first_len_q <= 5'd16;
			second_len_q <= 5'd16;
			group_count_q <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_OP: set_op_q <= cfg_data[1:0];
				CFG_FIRST_LEN: first_len_q <= cfg_data[4:0];
				CFG_SECOND_LEN: second_len_q <= cfg_data[4:0];
				CFG_GROUP_COUNT: group_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rsso_front u_front (.clk, .arst_n, .push, .full, .value, .first_len(first_len_q),
		.second_len(second_len_q), .beat(fb), .beat_valid(fv), .beat_ready(fr));
	rsso_fifo u_fifo (.clk, .arst_n, .wr_data(fb), .wr_en(fv), .wr_ready(fr),
		.rd_data(bb), .rd_valid(bv), .rd_en(bt));
	rsso_back u_back (.clk, .arst_n, .beat(bb), .beat_valid(bv), .beat_take(bt),
		.set_op(set_op_q), .group_count(group_count_q), .res(r), .res_valid(rv),
		.res_ready(pop));

	assign empty = !rv;
	assign kind = r.kind;
	assign group_index = r.group_index;
	assign position = r.position;
	assign element = r.element;
	assign last_in_group = r.last_in_group;
	assign max_set_size = r.max_set_size;
	assign total_count = r.total_count;

	a_sum_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (group_index == 32'd0 && !last_in_group))
		else $error("summary beat carries element fields");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(element) && $stable(kind)))
		else $error("result changed while stalled");
	a_elem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind) |-> (total_count == 40'd0))
		else $error("element beat carries summary fields");
endmodule
`default_nettype wire
